// ===== rtl/core/lrss_pkg.sv =====
// ----------------------------------------------------------------------------
// lrss_pkg
// shared types and codes of the led register shadow stager
// ----------------------------------------------------------------------------
package lrss_pkg;

    typedef enum logic [3:0] {
        MODE_CTL_ONE     = 4'd0,
        MODE_CTL_ALL     = 4'd1,
        MODE_CTL_RAW     = 4'd2,
        MODE_SYNC        = 4'd3,
        MODE_BRIGHT_ONE  = 4'd4,
        MODE_BRIGHT_ALL  = 4'd5,
        MODE_COMMIT      = 4'd6,
        MODE_READ_CTL    = 4'd7,
        MODE_READ_BRIGHT = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ACK        = 2'd0,
        KIND_BRIGHT_WR  = 2'd1,
        KIND_CTL_WR     = 2'd2,
        KIND_READ       = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_UPD,
        ST_CB_SCAN,
        ST_CB_EMIT,
        ST_CC_SCAN,
        ST_CC_EMIT,
        ST_ACK
    } state_t;

    localparam logic [7:0] BRIGHT_RESET = 8'hFF;
    localparam logic [7:0] CTL_RESET    = 8'h00;
    localparam logic [1:0] STATE_MASK   = 2'b11;

endpackage

// ===== rtl/core/led_register_shadow_stager_core.sv =====
// ----------------------------------------------------------------------------
// led_register_shadow_stager_core
// staged and sent shadow copies of led brightness and control registers,
// dirty tracking and commit sequencing
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_mode s_led_index s_reg_index
//          |           | s_led_state s_data_byte s_copy_select
//  m_      | out       | m_valid m_ready m_kind m_target_index m_byte_value
//          |           | m_pending m_last
//
//  one word at a time; s_ready is high only while the sequencer is idle
//  single-register commands pass a read and an update state, stage-all repeats
//  both for every register, commit scans the dirty bits and writes out each
//  dirty register, all on the single read/compare/write path of the shadow rams
//  reset clears the dirty bits, the ram valid bits and the result register
//  a full result register stalls the sequencer until m_ready
// ----------------------------------------------------------------------------
module led_register_shadow_stager_core
    import lrss_pkg::*;
#(
    parameter int NUM_LEDS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_mode,
    input  logic [3:0] s_led_index,
    input  logic [1:0] s_reg_index,
    input  logic [1:0] s_led_state,
    input  logic [7:0] s_data_byte,
    input  logic       s_copy_select,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [3:0] m_target_index,
    output logic [7:0] m_byte_value,
    output logic       m_pending,
    output logic       m_last
);

    localparam int NUM_CTL = (NUM_LEDS + 3) / 4;
    localparam int LED_W   = $clog2(NUM_LEDS);
    localparam int CTL_W   = (NUM_CTL > 1) ? $clog2(NUM_CTL) : 1;
    localparam int CNT_W   = $clog2(NUM_LEDS + NUM_CTL + 1);
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);
    localparam logic [CTL_W-1:0] CTL_LAST = CTL_W'(NUM_CTL - 1);

    // shadow rams
    logic [7:0] sb_mem [NUM_LEDS];
    logic [7:0] tb_mem [NUM_LEDS];
    logic [7:0] sc_mem [NUM_CTL];
    logic [7:0] tc_mem [NUM_CTL];

    state_t            state_reg, state_next;
    logic [LED_W-1:0]  idx_reg, idx_next;
    logic [CTL_W-1:0]  cidx;
    logic [3:0]        mode_reg;
    logic [3:0]        led_reg;
    logic [1:0]        regi_reg;
    logic [1:0]        st_reg;
    logic [7:0]        byte_reg;
    logic              sel_reg;
    logic              ok_reg, ok_next;

    logic [NUM_LEDS-1:0] bdirty_reg, bdirty_next;
    logic [NUM_CTL-1:0]  cdirty_reg, cdirty_next;
    logic [NUM_LEDS-1:0] sb_vld_reg, sb_vld_next;
    logic [NUM_LEDS-1:0] tb_vld_reg, tb_vld_next;
    logic [NUM_CTL-1:0]  sc_vld_reg, sc_vld_next;
    logic [NUM_CTL-1:0]  tc_vld_reg, tc_vld_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [7:0] sb_rd_reg, tb_rd_reg, sc_rd_reg, tc_rd_reg;
    logic       sb_rv_reg, tb_rv_reg, sc_rv_reg, tc_rv_reg;
    logic [7:0] sb_eff, tb_eff, sc_eff, tc_eff;

    logic       sb_we, tb_we, sc_we, tc_we;
    logic [7:0] sb_wdata, tb_wdata, sc_wdata, tc_wdata;

    logic [7:0] new_val, sent_val, mask;
    logic [2:0] sh;
    logic       differs;
    logic       accept;
    logic       out_free;

    logic       m_valid_reg;
    logic [1:0] m_kind_reg;
    logic [3:0] m_target_reg;
    logic [7:0] m_value_reg;
    logic       m_pending_reg;
    logic       m_last_reg;

    logic       out_load;
    logic [1:0] out_kind;
    logic [3:0] out_target;
    logic [7:0] out_value;
    logic       out_pending;
    logic       out_last;

    assign cidx     = idx_reg[CTL_W-1:0];
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign sb_eff = sb_rv_reg ? sb_rd_reg : BRIGHT_RESET;
    assign tb_eff = tb_rv_reg ? tb_rd_reg : BRIGHT_RESET;
    assign sc_eff = sc_rv_reg ? sc_rd_reg : CTL_RESET;
    assign tc_eff = tc_rv_reg ? tc_rd_reg : CTL_RESET;

    // shared merge and compare unit
    assign sh   = {led_reg[1:0], 1'b0};
    assign mask = 8'(STATE_MASK) << sh;
    always_comb begin
        unique case (mode_reg)
            MODE_CTL_ONE:    new_val = (sc_eff & ~mask) | (8'(st_reg) << sh);
            MODE_CTL_ALL:    new_val = {st_reg, st_reg, st_reg, st_reg};
            MODE_SYNC:       new_val = tc_eff;
            default:         new_val = byte_reg;
        endcase
        if (mode_reg == MODE_BRIGHT_ONE || mode_reg == MODE_BRIGHT_ALL) begin
            sent_val = tb_eff;
        end else begin
            sent_val = tc_eff;
        end
    end
    assign differs = (sent_val != new_val);

    // rams: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (sb_we) begin
            sb_mem[idx_reg] <= sb_wdata;
        end
        if (tb_we) begin
            tb_mem[idx_reg] <= tb_wdata;
        end
        if (sc_we) begin
            sc_mem[cidx] <= sc_wdata;
        end
        if (tc_we) begin
            tc_mem[cidx] <= tc_wdata;
        end
        sb_rd_reg <= sb_mem[idx_reg];
        tb_rd_reg <= tb_mem[idx_reg];
        sc_rd_reg <= sc_mem[cidx];
        tc_rd_reg <= tc_mem[cidx];
        sb_rv_reg <= sb_vld_reg[idx_reg];
        tb_rv_reg <= tb_vld_reg[idx_reg];
        sc_rv_reg <= sc_vld_reg[cidx];
        tc_rv_reg <= tc_vld_reg[cidx];
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        ok_next     = ok_reg;
        bdirty_next = bdirty_reg;
        cdirty_next = cdirty_reg;
        sb_vld_next = sb_vld_reg;
        tb_vld_next = tb_vld_reg;
        sc_vld_next = sc_vld_reg;
        tc_vld_next = tc_vld_reg;
        cnt_next    = cnt_reg;
        sb_we       = 1'b0;
        tb_we       = 1'b0;
        sc_we       = 1'b0;
        tc_we       = 1'b0;
        sb_wdata    = new_val;
        tb_wdata    = sb_eff;
        sc_wdata    = new_val;
        tc_wdata    = sc_eff;
        out_load    = 1'b0;
        out_kind    = KIND_ACK;
        out_target  = 4'd0;
        out_value   = 8'd0;
        out_pending = (cnt_reg != '0);
        out_last    = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_mode)
                        MODE_CTL_ONE: begin
                            idx_next   = LED_W'(s_led_index >> 2);
                            state_next = (32'(s_led_index) < NUM_LEDS) ? ST_RD : ST_ACK;
                        end
                        MODE_CTL_ALL, MODE_BRIGHT_ALL: begin
                            idx_next   = '0;
                            state_next = ST_RD;
                        end
                        MODE_CTL_RAW, MODE_SYNC: begin
                            idx_next   = LED_W'(s_reg_index);
                            state_next = (32'(s_reg_index) < NUM_CTL) ? ST_RD : ST_ACK;
                        end
                        MODE_BRIGHT_ONE: begin
                            idx_next   = LED_W'(s_led_index);
                            state_next = (32'(s_led_index) < NUM_LEDS) ? ST_RD : ST_ACK;
                        end
                        MODE_COMMIT: begin
                            idx_next   = '0;
                            state_next = (cnt_reg != '0) ? ST_CB_SCAN : ST_ACK;
                        end
                        MODE_READ_CTL: begin
                            idx_next   = LED_W'(s_reg_index);
                            ok_next    = (32'(s_reg_index) < NUM_CTL);
                            state_next = ST_RD;
                        end
                        MODE_READ_BRIGHT: begin
                            idx_next   = LED_W'(s_led_index);
                            ok_next    = (32'(s_led_index) < NUM_LEDS);
                            state_next = ST_RD;
                        end
                        default: begin
                            state_next = ST_ACK;
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                unique case (mode_reg)
                    MODE_CTL_ONE: begin
                        sc_we             = 1'b1;
                        sc_vld_next[cidx] = 1'b1;
                        if (differs && !cdirty_reg[cidx]) begin
                            cdirty_next[cidx] = 1'b1;
                            cnt_next          = cnt_reg + CNT_W'(1);
                        end
                        state_next = ST_ACK;
                    end
                    MODE_CTL_ALL, MODE_CTL_RAW: begin
                        if (differs) begin
                            sc_we             = 1'b1;
                            sc_vld_next[cidx] = 1'b1;
                            if (!cdirty_reg[cidx]) begin
                                cdirty_next[cidx] = 1'b1;
                                cnt_next          = cnt_reg + CNT_W'(1);
                            end
                        end
                        if (mode_reg == MODE_CTL_ALL && cidx != CTL_LAST) begin
                            idx_next   = idx_reg + LED_W'(1);
                            state_next = ST_RD;
                        end else begin
                            state_next = ST_ACK;
                        end
                    end
                    MODE_SYNC: begin
                        sc_we             = 1'b1;
                        sc_vld_next[cidx] = 1'b1;
                        state_next        = ST_ACK;
                    end
                    MODE_BRIGHT_ONE, MODE_BRIGHT_ALL: begin
                        if (differs) begin
                            sb_we                = 1'b1;
                            sb_vld_next[idx_reg] = 1'b1;
                            if (!bdirty_reg[idx_reg]) begin
                                bdirty_next[idx_reg] = 1'b1;
                                cnt_next             = cnt_reg + CNT_W'(1);
                            end
                        end
                        if (mode_reg == MODE_BRIGHT_ALL && idx_reg != LED_LAST) begin
                            idx_next   = idx_reg + LED_W'(1);
                            state_next = ST_RD;
                        end else begin
                            state_next = ST_ACK;
                        end
                    end
                    MODE_READ_CTL: begin
                        out_kind   = KIND_READ;
                        out_target = {2'b00, regi_reg};
                        out_value  = ok_reg ? (sel_reg ? tc_eff : sc_eff) : 8'd0;
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        out_kind   = KIND_READ;
                        out_target = led_reg;
                        out_value  = ok_reg ? (sel_reg ? tb_eff : sb_eff) : 8'd0;
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_CB_SCAN: begin
                if (bdirty_reg[idx_reg]) begin
                    state_next = ST_CB_EMIT;
                end else if (idx_reg == LED_LAST) begin
                    idx_next   = '0;
                    state_next = ST_CC_SCAN;
                end else begin
                    idx_next = idx_reg + LED_W'(1);
                end
            end
            ST_CB_EMIT: begin
                out_kind    = KIND_BRIGHT_WR;
                out_target  = 4'(idx_reg);
                out_value   = sb_eff;
                out_pending = 1'b0;
                out_last    = (cnt_reg == CNT_W'(1));
                if (out_free) begin
                    out_load             = 1'b1;
                    tb_we                = 1'b1;
                    tb_vld_next[idx_reg] = 1'b1;
                    bdirty_next[idx_reg] = 1'b0;
                    cnt_next             = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else if (idx_reg == LED_LAST) begin
                        idx_next   = '0;
                        state_next = ST_CC_SCAN;
                    end else begin
                        idx_next   = idx_reg + LED_W'(1);
                        state_next = ST_CB_SCAN;
                    end
                end
            end
            ST_CC_SCAN: begin
                if (cdirty_reg[cidx]) begin
                    state_next = ST_CC_EMIT;
                end else if (cidx == CTL_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + LED_W'(1);
                end
            end
            ST_CC_EMIT: begin
                out_kind    = KIND_CTL_WR;
                out_target  = 4'(cidx);
                out_value   = sc_eff;
                out_pending = 1'b0;
                out_last    = (cnt_reg == CNT_W'(1));
                if (out_free) begin
                    out_load          = 1'b1;
                    tc_we             = 1'b1;
                    tc_vld_next[cidx] = 1'b1;
                    cdirty_next[cidx] = 1'b0;
                    cnt_next          = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1) || cidx == CTL_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + LED_W'(1);
                        state_next = ST_CC_SCAN;
                    end
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            bdirty_reg <= '0;
            cdirty_reg <= '0;
            sb_vld_reg <= '0;
            tb_vld_reg <= '0;
            sc_vld_reg <= '0;
            tc_vld_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            bdirty_reg <= bdirty_next;
            cdirty_reg <= cdirty_next;
            sb_vld_reg <= sb_vld_next;
            tb_vld_reg <= tb_vld_next;
            sc_vld_reg <= sc_vld_next;
            tc_vld_reg <= tc_vld_next;
            cnt_reg    <= cnt_next;
        end
    end

    // command word and loop index
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        ok_reg  <= ok_next;
        if (accept) begin
            mode_reg <= s_mode;
            led_reg  <= s_led_index;
            regi_reg <= s_reg_index;
            st_reg   <= s_led_state;
            byte_reg <= s_data_byte;
            sel_reg  <= s_copy_select;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg    <= out_kind;
            m_target_reg  <= out_target;
            m_value_reg   <= out_value;
            m_pending_reg <= out_pending;
            m_last_reg    <= out_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_target_index = m_target_reg;
    assign m_byte_value   = m_value_reg;
    assign m_pending      = m_pending_reg;
    assign m_last         = m_last_reg;

endmodule
